/* design/fttu_pkg.sv */
// Shared types, codes and constants for the four-timer tick unit.
// No dependencies; the timer and top-level design files import this package.

package fttu_pkg;

    // Item codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Timer selects for a counter write
    localparam logic [1:0] SEL_TIMER0 = 2'd0;
    localparam logic [1:0] SEL_TIMER1 = 2'd1;
    localparam logic [1:0] SEL_TIMER2 = 2'd2;
    localparam logic [1:0] SEL_TIMER3 = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_T0_CTRL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_T1_CTRL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_T2_CTRL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_T2_PERIOD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_T3_CTRL    = 3'd4;

    // Register reset values
    localparam logic [7:0] T0_CTRL_RESET   = 8'hFF;
    localparam logic [7:0] T2_PERIOD_RESET = 8'hFF;

    // Prescaler ratio tables
    localparam logic [8:0] T0_RATIO [8] = '{9'd2, 9'd4, 9'd8, 9'd16,
                                            9'd32, 9'd64, 9'd128, 9'd256};
    localparam logic [3:0] T13_RATIO [4] = '{4'd1, 4'd2, 4'd4, 4'd8};
    localparam logic [4:0] T2_RATIO [4] = '{5'd1, 5'd4, 5'd16, 5'd16};

    typedef struct packed {
        logic [7:0] t0_ctrl;
        logic [7:0] t1_ctrl;
        logic [7:0] t2_ctrl;
        logic [7:0] t2_period;
        logic [7:0] t3_ctrl;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  timer_select;
        logic [15:0] write_value;
        logic [3:0]  clear_mask;
    } item_t;

    typedef struct packed {
        logic [15:0] count0;
        logic [15:0] count1;
        logic [7:0]  count2;
        logic [15:0] count3;
        logic [3:0]  flags;
        logic [3:0]  irq_events;
    } result_t;

endpackage

/* design/fttu_if.sv */
// Valid/ready channel interfaces for the four-timer tick unit.
// No dependencies; widths follow the fttu_pkg item and result fields.

interface fttu_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [1:0]  timer_select;
    logic [15:0] write_value;
    logic [3:0]  clear_mask;

    modport source (output valid, opcode, timer_select, write_value, clear_mask,
                    input ready);
    modport sink   (input valid, opcode, timer_select, write_value, clear_mask,
                    output ready);
endinterface

interface fttu_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] count0;
    logic [15:0] count1;
    logic [7:0]  count2;
    logic [15:0] count3;
    logic [3:0]  flags;
    logic [3:0]  irq_events;

    modport source (output valid, count0, count1, count2, count3, flags, irq_events,
                    input ready);
    modport sink   (input valid, count0, count1, count2, count3, flags, irq_events,
                    output ready);
endinterface

/* design/fttu_timers.sv */
// Timer state (counters, prescalers, postscaler, flags) and its one-pass update.
// Depends on fttu_pkg for cfg_t, item_t, result_t, codes and ratio tables.

module fttu_timers import fttu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    logic [15:0] cnt0_reg, cnt0_next;
    logic [15:0] cnt1_reg, cnt1_next;
    logic [7:0]  cnt2_reg, cnt2_next;
    logic [15:0] cnt3_reg, cnt3_next;
    logic [8:0]  pre0_reg, pre0_next;
    logic [3:0]  pre1_reg, pre1_next;
    logic [4:0]  pre2_reg, pre2_next;
    logic [3:0]  post2_reg, post2_next;
    logic [3:0]  pre3_reg, pre3_next;
    logic [3:0]  flags_reg, flags_next;
    logic [3:0]  events;

    logic [9:0]  pre0_inc;
    logic [9:0]  t0_ratio;
    logic [4:0]  pre1_inc;
    logic [4:0]  pre3_inc;
    logic [5:0]  pre2_inc;
    logic [8:0]  cnt2_inc;
    logic [4:0]  post2_inc;
    logic [4:0]  post2_ratio;

    // Increments and ratios
    always_comb
    begin
        pre0_inc    = {1'b0, pre0_reg} + 10'd1;
        t0_ratio    = cfg.t0_ctrl[3] ? 10'd1 : {1'b0, T0_RATIO[cfg.t0_ctrl[2:0]]};
        pre1_inc    = {1'b0, pre1_reg} + 5'd1;
        pre3_inc    = {1'b0, pre3_reg} + 5'd1;
        pre2_inc    = {1'b0, pre2_reg} + 6'd1;
        cnt2_inc    = {1'b0, cnt2_reg} + 9'd1;
        post2_inc   = {1'b0, post2_reg} + 5'd1;
        post2_ratio = {1'b0, cfg.t2_ctrl[6:3]} + 5'd1;
    end

    // Next state for one item
    always_comb
    begin
        cnt0_next  = cnt0_reg;
        cnt1_next  = cnt1_reg;
        cnt2_next  = cnt2_reg;
        cnt3_next  = cnt3_reg;
        pre0_next  = pre0_reg;
        pre1_next  = pre1_reg;
        pre2_next  = pre2_reg;
        post2_next = post2_reg;
        pre3_next  = pre3_reg;
        flags_next = flags_reg;
        events     = '0;

        case (item.opcode)
            OP_TICK:
            begin
                // Timer0: prescaler or bypass, 8- or 16-bit count
                if (cfg.t0_ctrl[7])
                begin
                    if (pre0_inc >= t0_ratio)
                    begin
                        pre0_next = '0;
                        if (cfg.t0_ctrl[6])
                        begin
                            cnt0_next = {cnt0_reg[15:8], cnt0_reg[7:0] + 8'd1};
                            events[0] = (cnt0_reg[7:0] == 8'hFF);
                        end
                        else
                        begin
                            cnt0_next = cnt0_reg + 16'd1;
                            events[0] = (cnt0_reg == 16'hFFFF);
                        end
                    end
                    else
                    begin
                        pre0_next = pre0_inc[8:0];
                    end
                end

                // Timer1
                if (cfg.t1_ctrl[0])
                begin
                    if (pre1_inc >= {1'b0, T13_RATIO[cfg.t1_ctrl[5:4]]})
                    begin
                        pre1_next = '0;
                        cnt1_next = cnt1_reg + 16'd1;
                        events[1] = (cnt1_reg == 16'hFFFF);
                    end
                    else
                    begin
                        pre1_next = pre1_inc[3:0];
                    end
                end

                // Timer2: period match clears and counts the postscaler
                if (cfg.t2_ctrl[2])
                begin
                    if (pre2_inc >= {1'b0, T2_RATIO[cfg.t2_ctrl[1:0]]})
                    begin
                        pre2_next = '0;
                        if (cnt2_inc <= {1'b0, cfg.t2_period})
                        begin
                            cnt2_next = cnt2_inc[7:0];
                        end
                        else
                        begin
                            cnt2_next = '0;
                            if (post2_inc >= post2_ratio)
                            begin
                                post2_next = '0;
                                events[2]  = 1'b1;
                            end
                            else
                            begin
                                post2_next = post2_inc[3:0];
                            end
                        end
                    end
                    else
                    begin
                        pre2_next = pre2_inc[4:0];
                    end
                end

                // Timer3
                if (cfg.t3_ctrl[0])
                begin
                    if (pre3_inc >= {1'b0, T13_RATIO[cfg.t3_ctrl[5:4]]})
                    begin
                        pre3_next = '0;
                        cnt3_next = cnt3_reg + 16'd1;
                        events[3] = (cnt3_reg == 16'hFFFF);
                    end
                    else
                    begin
                        pre3_next = pre3_inc[3:0];
                    end
                end

                flags_next = flags_reg | events;
            end
            OP_WRITE:
            begin
                case (item.timer_select)
                    SEL_TIMER0: cnt0_next = item.write_value;
                    SEL_TIMER1: cnt1_next = item.write_value;
                    SEL_TIMER2: cnt2_next = item.write_value[7:0];
                    default:    cnt3_next = item.write_value;
                endcase
            end
            OP_CLEAR:
            begin
                flags_next = flags_reg & ~item.clear_mask;
            end
            default:
            begin
                flags_next = flags_reg;
            end
        endcase
    end

    // Result fields are the state after this item
    always_comb
    begin
        res.count0     = cnt0_next;
        res.count1     = cnt1_next;
        res.count2     = cnt2_next;
        res.count3     = cnt3_next;
        res.flags      = flags_next;
        res.irq_events = events;
    end

    // Commit state when the item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt0_reg  <= '0;
            cnt1_reg  <= '0;
            cnt2_reg  <= '0;
            cnt3_reg  <= '0;
            pre0_reg  <= '0;
            pre1_reg  <= '0;
            pre2_reg  <= '0;
            post2_reg <= '0;
            pre3_reg  <= '0;
            flags_reg <= '0;
        end
        else if (step)
        begin
            cnt0_reg  <= cnt0_next;
            cnt1_reg  <= cnt1_next;
            cnt2_reg  <= cnt2_next;
            cnt3_reg  <= cnt3_next;
            pre0_reg  <= pre0_next;
            pre1_reg  <= pre1_next;
            pre2_reg  <= pre2_next;
            post2_reg <= post2_next;
            pre3_reg  <= pre3_next;
            flags_reg <= flags_next;
        end
    end

endmodule

/* design/four_timer_tick_unit.sv */
// Top level of the four-timer tick unit: item register, result register, config registers.
// Depends on fttu_pkg, fttu_item_if/fttu_result_if and fttu_timers.
//
// Usage:
//   item   : valid/ready channel; each transfer is one tick (opcode tick), one counter
//            write (opcode write, timer_select, write_value) or one flag clear
//            (opcode clear, clear_mask). Any other opcode changes nothing.
//   result : valid/ready channel; exactly one transfer per item, in order, carrying all
//            four counters, the sticky flags and the flag events raised by that item.
//   cfg    : cfg_we/cfg_index/cfg_wdata write the five control registers; write them
//            only while no item is in flight.
// The item register takes an item at its transfer edge; the timer update then passes it into
// the result register at an edge where the result register is empty or being taken.
// Throughput is one item per clock while the receiver does not stall; the timer update
// reads the timer state and commits its next value as the item moves on, so consecutive
// items never wait on each other.
// Reset clears all counters, prescalers, the postscaler and the flags, loads the
// control registers with their reset values and empties both registers.
// When the receiver stalls, the result register holds, and the item register still
// takes one more item; after that ready drops until the result is taken.

module four_timer_tick_unit import fttu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    fttu_item_if.sink            item,
    fttu_result_if.source        result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    logic    result_valid_reg;
    result_t res_next;
    logic    advance;
    logic    take;

    // Pipeline control
    assign advance    = item_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;
    assign take       = item.valid && item.ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.t0_ctrl   <= T0_CTRL_RESET;
            cfg_reg.t1_ctrl   <= '0;
            cfg_reg.t2_ctrl   <= '0;
            cfg_reg.t2_period <= T2_PERIOD_RESET;
            cfg_reg.t3_ctrl   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_T0_CTRL:   cfg_reg.t0_ctrl   <= cfg_wdata;
                REG_T1_CTRL:   cfg_reg.t1_ctrl   <= cfg_wdata;
                REG_T2_CTRL:   cfg_reg.t2_ctrl   <= cfg_wdata;
                REG_T2_PERIOD: cfg_reg.t2_period <= cfg_wdata;
                REG_T3_CTRL:   cfg_reg.t3_ctrl   <= cfg_wdata;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // Item register: hold valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    // Item register: capture payload on transfer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.opcode       <= item.opcode;
            item_reg.timer_select <= item.timer_select;
            item_reg.write_value  <= item.write_value;
            item_reg.clear_mask   <= item.clear_mask;
        end
    end

    fttu_timers u_timers
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (res_next)
    );

    // Result register: valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Result register: payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= res_next;
        end
    end

    assign result.valid      = result_valid_reg;
    assign result.count0     = result_reg.count0;
    assign result.count1     = result_reg.count1;
    assign result.count2     = result_reg.count2;
    assign result.count3     = result_reg.count3;
    assign result.flags      = result_reg.flags;
    assign result.irq_events = result_reg.irq_events;

    // A raised event always shows in the sticky flags of the same result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> ((result_reg.irq_events & ~result_reg.flags) == 4'd0))
        else $error("irq event without matching flag");

    // Only a tick can raise events
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.opcode != OP_TICK) |=> (result_reg.irq_events == 4'd0))
        else $error("irq event on a non-tick item");

    // A flag clear leaves no masked flag set
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.opcode == OP_CLEAR)
        |=> ((result_reg.flags & $past(item_reg.clear_mask)) == 4'd0))
        else $error("flag clear left a masked flag set");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for four_timer_tick_unit: directed and random item traffic
// with random idling on both channels, checked against an in-bench timer predictor.
// Depends on fttu_pkg, the fttu_item_if/fttu_result_if interfaces and the design top.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fttu_pkg::*;

    localparam logic [1:0]  OP_UNUSED       = 2'd3;
    localparam int unsigned CYCLE_LIMIT     = 250000;
    localparam int unsigned MAX_IDLE        = 18;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned RANDOM_PHASES   = 10;
    localparam int unsigned ITEMS_PER_PHASE = 50;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    fttu_item_if   item_ch ();
    fttu_result_if result_ch ();

    four_timer_tick_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Timer predictor state, mirrored at the block's widths
    cfg_t        timer_cfg;
    logic [15:0] t0_cnt;
    logic [15:0] t1_cnt;
    logic [7:0]  t2_cnt;
    logic [15:0] t3_cnt;
    logic [8:0]  t0_pre;
    logic [3:0]  t1_pre;
    logic [4:0]  t2_pre;
    logic [3:0]  t2_post;
    logic [3:0]  t3_pre;
    logic [3:0]  flag_state;

    result_t     expected_results [$];
    int unsigned error_count  = 0;
    int unsigned result_count = 0;
    int unsigned cycle_count  = 0;
    int unsigned gap_max      = 0;
    int unsigned stall_max    = 0;

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_results.size());
            $display("[four_timer_tick_unit] ERROR");
            $finish;
        end
    end

    // True when this increment brings a prescaler or postscaler count to or past its ratio
    function automatic bit prescale_wraps(int unsigned count, int unsigned ratio);
        return (count + 1) >= ratio;
    endfunction

    // Advance timer 1 or timer 3; returns the overflow event
    function automatic bit tick_wide_timer(input logic [7:0] ctrl, inout logic [3:0] pre,
                                           inout logic [15:0] cnt);
        int unsigned ratio;
        ratio = 1 << ctrl[5:4];
        if (!ctrl[0])
            return 1'b0;
        if (!prescale_wraps(pre, ratio))
        begin
            pre = pre + 4'd1;
            return 1'b0;
        end
        pre = '0;
        cnt = cnt + 16'd1;
        return cnt == 16'h0000;
    endfunction

    // Apply one item to the timer state and return the result it should produce
    function automatic result_t predict_timers(item_t it);
        result_t     res;
        logic [3:0]  events;
        int unsigned ratio;
        events = '0;
        case (it.opcode)
            OP_TICK:
            begin
                // timer0: bypass or 1:2..1:256, 8-bit mode holds the high byte
                if (timer_cfg.t0_ctrl[7])
                begin
                    ratio = timer_cfg.t0_ctrl[3] ? 1 : (2 << timer_cfg.t0_ctrl[2:0]);
                    if (prescale_wraps(t0_pre, ratio))
                    begin
                        t0_pre = '0;
                        if (timer_cfg.t0_ctrl[6])
                        begin
                            t0_cnt[7:0] = t0_cnt[7:0] + 8'd1;
                            events[0] = (t0_cnt[7:0] == 8'h00);
                        end
                        else
                        begin
                            t0_cnt = t0_cnt + 16'd1;
                            events[0] = (t0_cnt == 16'h0000);
                        end
                    end
                    else
                        t0_pre = t0_pre + 9'd1;
                end
                events[1] = tick_wide_timer(timer_cfg.t1_ctrl, t1_pre, t1_cnt);
                // timer2: clear past the period, postscale the matches
                if (timer_cfg.t2_ctrl[2])
                begin
                    case (timer_cfg.t2_ctrl[1:0])
                        2'd0:    ratio = 1;
                        2'd1:    ratio = 4;
                        default: ratio = 16;
                    endcase
                    if (prescale_wraps(t2_pre, ratio))
                    begin
                        t2_pre = '0;
                        if (int'(t2_cnt) + 1 <= int'(timer_cfg.t2_period))
                            t2_cnt = t2_cnt + 8'd1;
                        else
                        begin
                            t2_cnt = '0;
                            if (prescale_wraps(t2_post, int'(timer_cfg.t2_ctrl[6:3]) + 1))
                            begin
                                t2_post = '0;
                                events[2] = 1'b1;
                            end
                            else
                                t2_post = t2_post + 4'd1;
                        end
                    end
                    else
                        t2_pre = t2_pre + 5'd1;
                end
                events[3] = tick_wide_timer(timer_cfg.t3_ctrl, t3_pre, t3_cnt);
                flag_state = flag_state | events;
            end
            OP_WRITE:
            begin
                case (it.timer_select)
                    SEL_TIMER0: t0_cnt = it.write_value;
                    SEL_TIMER1: t1_cnt = it.write_value;
                    SEL_TIMER2: t2_cnt = it.write_value[7:0];
                    default:    t3_cnt = it.write_value;
                endcase
            end
            OP_CLEAR:
                flag_state = flag_state & ~it.clear_mask;
            default:
                ;
        endcase
        res.count0     = t0_cnt;
        res.count1     = t1_cnt;
        res.count2     = t2_cnt;
        res.count3     = t3_cnt;
        res.flags      = flag_state;
        res.irq_events = events;
        return res;
    endfunction

    function automatic item_t make_item(logic [1:0] opcode, logic [1:0] sel,
                                        logic [15:0] value, logic [3:0] mask);
        item_t it;
        it.opcode       = opcode;
        it.timer_select = sel;
        it.write_value  = value;
        it.clear_mask   = mask;
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch at result %0d: %s got %h expected %h",
                 result_count, what, got, want);
        error_count++;
    endtask

    // Compare one result transfer with the oldest expectation
    task automatic check_result(result_t got);
        result_t want;
        result_count++;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result with no item pending, count0", got.count0, 16'hxxxx);
            return;
        end
        want = expected_results.pop_front();
        if (got.count0 !== want.count0)
            report_mismatch("count0", got.count0, want.count0);
        if (got.count1 !== want.count1)
            report_mismatch("count1", got.count1, want.count1);
        if (got.count2 !== want.count2)
            report_mismatch("count2", 16'(got.count2), 16'(want.count2));
        if (got.count3 !== want.count3)
            report_mismatch("count3", got.count3, want.count3);
        if (got.flags !== want.flags)
            report_mismatch("flags", 16'(got.flags), 16'(want.flags));
        if (got.irq_events !== want.irq_events)
            report_mismatch("irq_events", 16'(got.irq_events), 16'(want.irq_events));
    endtask

    // Drive one item after a random gap and hold it until the transfer
    task automatic send_item(item_t it);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.opcode       <= it.opcode;
        item_ch.timer_select <= it.timer_select;
        item_ch.write_value  <= it.write_value;
        item_ch.clear_mask   <= it.clear_mask;
        do
            @(posedge clk);
        while (!item_ch.ready);
        expected_results.push_back(predict_timers(it));
    endtask

    // Drop valid and wait until every result is back and the pipeline is empty
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all five control registers in index order; block must be idle
    task automatic program_timers(cfg_t c);
        logic [7:0]           values [5];
        logic [CFG_IDX_W-1:0] indexes [5];
        values  = '{c.t0_ctrl, c.t1_ctrl, c.t2_ctrl, c.t2_period, c.t3_ctrl};
        indexes = '{REG_T0_CTRL, REG_T1_CTRL, REG_T2_CTRL, REG_T2_PERIOD, REG_T3_CTRL};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= indexes[i];
            cfg_wdata <= values[i];
            @(posedge clk);
        end
        cfg_we    <= 1'b0;
        timer_cfg = c;
    endtask

    // Reset configuration: timer0 bypassed in 8-bit mode, others off
    task automatic test_reset_defaults();
        gap_max   = 2;
        stall_max = 2;
        send_item(make_item(OP_TICK, SEL_TIMER0, 16'h0000, 4'h0));
        send_item(make_item(OP_WRITE, SEL_TIMER0, 16'hFFFF, 4'h0));
        // low byte wraps, high byte held, flag raised
        send_item(make_item(OP_TICK, SEL_TIMER3, 16'hFFFF, 4'hF));
        send_item(make_item(OP_WRITE, SEL_TIMER1, 16'hFFFF, 4'h0));
        send_item(make_item(OP_WRITE, SEL_TIMER2, 16'hFFFF, 4'h0));
        send_item(make_item(OP_WRITE, SEL_TIMER3, 16'h0000, 4'hF));
        send_item(make_item(OP_CLEAR, SEL_TIMER0, 16'h0000, 4'h0));
        send_item(make_item(OP_UNUSED, SEL_TIMER3, 16'hFFFF, 4'hF));
        send_item(make_item(OP_CLEAR, SEL_TIMER0, 16'h0000, 4'hF));
    endtask

    // 16-bit wraps on timers 0, 1 and 3, timer2 at 255 with period 255, write mid-prescale
    task automatic test_overflow_wrap();
        drain_results();
        program_timers('{t0_ctrl: 8'h80, t1_ctrl: 8'h01, t2_ctrl: 8'h04,
                         t2_period: 8'hFF, t3_ctrl: 8'h01});
        send_item(make_item(OP_WRITE, SEL_TIMER0, 16'hFFFF, 4'h0));
        send_item(make_item(OP_WRITE, SEL_TIMER3, 16'hFFFF, 4'h0));
        send_item(make_item(OP_TICK, SEL_TIMER0, 16'h0000, 4'h0));
        send_item(make_item(OP_TICK, SEL_TIMER0, 16'h0000, 4'h0));
        send_item(make_item(OP_TICK, SEL_TIMER0, 16'h0000, 4'h0));
        // the write must not reset the half-done timer0 prescale
        send_item(make_item(OP_WRITE, SEL_TIMER0, 16'h1234, 4'h0));
        send_item(make_item(OP_TICK, SEL_TIMER0, 16'h0000, 4'h0));
        send_item(make_item(OP_CLEAR, SEL_TIMER0, 16'h0000, 4'h5));
    endtask

    // Build up prescaler and postscaler counts, then lower every ratio to or below them
    task automatic test_ratio_lowered();
        drain_results();
        program_timers('{t0_ctrl: 8'h87, t1_ctrl: 8'h31, t2_ctrl: 8'h7D,
                         t2_period: 8'h00, t3_ctrl: 8'h31});
        repeat (5)
            send_item(make_item(OP_TICK, SEL_TIMER0, 16'h0000, 4'h0));
        drain_results();
        program_timers('{t0_ctrl: 8'h80, t1_ctrl: 8'h11, t2_ctrl: 8'h04,
                         t2_period: 8'h00, t3_ctrl: 8'h01});
        send_item(make_item(OP_TICK, SEL_TIMER0, 16'h0000, 4'h0));
    endtask

    // Random phases: new settings each phase, mostly ticks with writes near wrap points
    task automatic test_random_traffic();
        cfg_t        c;
        item_t       it;
        int unsigned sent;
        int unsigned pick;
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            // pick settings: all ones, all zeros, then random with timers mostly on
            if (phase == 0)
                c = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
            else if (phase == 1)
                c = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            else
            begin
                c.t0_ctrl = 8'($urandom_range(0, 255));
                c.t1_ctrl = 8'($urandom_range(0, 255));
                c.t2_ctrl = 8'($urandom_range(0, 255));
                c.t3_ctrl = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 4) != 0)
                    c.t0_ctrl[7] = 1'b1;
                if ($urandom_range(0, 4) != 0)
                    c.t1_ctrl[0] = 1'b1;
                if ($urandom_range(0, 4) != 0)
                    c.t2_ctrl[2] = 1'b1;
                if ($urandom_range(0, 4) != 0)
                    c.t3_ctrl[0] = 1'b1;
                c.t2_period = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7))
                                                          : 8'($urandom_range(0, 255));
            end
            program_timers(c);

            // idling: none first, the longest next, then a random mix
            if (phase == 0)
            begin
                gap_max   = 0;
                stall_max = 0;
            end
            else if (phase == 1)
            begin
                gap_max   = MAX_IDLE;
                stall_max = MAX_IDLE;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       gap_max = 0;
                    1:       gap_max = 4;
                    default: gap_max = MAX_IDLE;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_max = 0;
                    1:       stall_max = 4;
                    default: stall_max = MAX_IDLE;
                endcase
            end

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                pick            = $urandom_range(0, 99);
                it.timer_select = 2'($urandom_range(0, 3));
                it.write_value  = 16'($urandom_range(0, 16'hFFFF));
                it.clear_mask   = 4'($urandom_range(0, 15));
                if (pick < 70)
                    it.opcode = OP_TICK;
                else if (pick < 85)
                begin
                    it.opcode = OP_WRITE;
                    // land close to a 16-bit or 8-bit wrap most of the time
                    case ($urandom_range(0, 2))
                        0:       it.write_value = 16'hFFFF - 16'($urandom_range(0, 8));
                        1:       it.write_value[7:0] = 8'hFF - 8'($urandom_range(0, 8));
                        default: ;
                    endcase
                end
                else if (pick < 95)
                    it.opcode = OP_CLEAR;
                else
                    it.opcode = OP_UNUSED;
                send_item(it);
                if (it.opcode != OP_UNUSED)
                    sent++;
            end
        end
    endtask

    // Take result transfers with random stalls and check each one
    initial
    begin : result_sink
        int unsigned stall;
        result_t     got;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = $urandom_range(0, stall_max);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            got.count0     = result_ch.count0;
            got.count1     = result_ch.count1;
            got.count2     = result_ch.count2;
            got.count3     = result_ch.count3;
            got.flags      = result_ch.flags;
            got.irq_events = result_ch.irq_events;
            check_result(got);
        end
    end

    // Reset, run the tests in turn, then wait for the last result
    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= '0;
        cfg_wdata            <= '0;
        item_ch.valid        <= 1'b0;
        item_ch.opcode       <= OP_TICK;
        item_ch.timer_select <= SEL_TIMER0;
        item_ch.write_value  <= '0;
        item_ch.clear_mask   <= '0;

        timer_cfg  = '{T0_CTRL_RESET, 8'h00, 8'h00, T2_PERIOD_RESET, 8'h00};
        t0_cnt     = '0;
        t1_cnt     = '0;
        t2_cnt     = '0;
        t3_cnt     = '0;
        t0_pre     = '0;
        t1_pre     = '0;
        t2_pre     = '0;
        t2_post    = '0;
        t3_pre     = '0;
        flag_state = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_overflow_wrap();
        test_ratio_lowered();
        test_random_traffic();
        drain_results();

        if (error_count == 0)
            $display("[four_timer_tick_unit] OK");
        else
            $display("[four_timer_tick_unit] ERROR");
        $finish;
    end

endmodule
